### design/vagdec_pkg.sv
// Shared widths, constants, types and the predictor table of the VAG ADPCM byte decoder.
package vagdec_pkg;

	localparam int BYTE_W   = 8;
	localparam int CODE_W   = 4;
	localparam int POS_W    = 4;
	localparam int PRED_W   = 3;
	localparam int SHIFT_W  = 4;
	localparam int HIST_W   = 32;
	localparam int COEF_W   = 8;
	localparam int FRAC_W   = 6;
	localparam int SAMPLE_W = 16;
	localparam int BASE_W   = 16;

	localparam logic [BYTE_W-1:0] HEADER_FILL = 8'hC0;
	localparam logic [PRED_W-1:0] PRED_MAX    = 3'd4;
	localparam logic [POS_W-1:0]  POS_HEADER  = 4'd0;
	localparam logic [POS_W-1:0]  POS_FIRST_SAMPLE = 4'd2;

	typedef logic signed [HIST_W-1:0]   hist_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One accepted byte, ready for decoding.
	typedef struct packed {
		logic                 clr;    // stream start: history clears before this byte
		logic                 emit;   // sample byte of a normal block
		logic [BYTE_W-1:0]    codes;  // two codes, low nibble first
		logic [PRED_W-1:0]    pred;
		logic [SHIFT_W-1:0]   shift;
	} item_t;

	// Decode slot status handed from the framing stage to the datapath.
	typedef struct packed {
		logic  valid;
		logic  phase;  // 0: low nibble, 1: high nibble
		item_t item;
	} slot_t;

	function automatic coef_t coef_newest(input logic [PRED_W-1:0] p);
		coef_t c;
		unique case (p)
			3'd0:    c = 8'sd0;
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic coef_t coef_older(input logic [PRED_W-1:0] p);
		coef_t c;
		unique case (p)
			3'd0:    c = 8'sd0;
			3'd1:    c = 8'sd0;
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

### design/vagdec_frame.sv
// Input register stage: block position tracking, header parsing and the decode slot.
module vagdec_frame (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vagdec_pkg::BYTE_W-1:0] in_byte,
	input  logic                          in_start,
	input  logic                          adv,
	output vagdec_pkg::slot_t             slot
);

	logic [vagdec_pkg::POS_W-1:0]   pos_q;
	logic [vagdec_pkg::PRED_W-1:0]  pred_q;
	logic [vagdec_pkg::SHIFT_W-1:0] shift_q;
	logic                           fill_q;
	logic                           valid_q;
	logic                           phase_q;
	vagdec_pkg::item_t              item_s1;

	logic                           accept;
	logic                           done;
	logic [vagdec_pkg::POS_W-1:0]   pos;
	logic [vagdec_pkg::PRED_W-1:0]  hdr_pred;

	assign done     = valid_q && adv && (!item_s1.emit || phase_q);
	assign in_ready = !valid_q || done;
	assign accept   = in_valid && in_ready;
	assign pos      = in_start ? vagdec_pkg::POS_HEADER : pos_q;
	assign hdr_pred = (in_byte[7:4] > 4'(vagdec_pkg::PRED_MAX)) ? '0 : in_byte[6:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			pred_q  <= '0;
			shift_q <= '0;
			fill_q  <= 1'b0;
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= pos + 1'b1;
				if (pos == vagdec_pkg::POS_HEADER) begin
					pred_q  <= hdr_pred;
					shift_q <= in_byte[3:0];
					fill_q  <= (in_byte == vagdec_pkg::HEADER_FILL);
				end
				valid_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (done) begin
				valid_q <= 1'b0;
				phase_q <= 1'b0;
			end else if (valid_q && adv) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.clr   <= in_start;
			item_s1.emit  <= (pos >= vagdec_pkg::POS_FIRST_SAMPLE) && !fill_q;
			item_s1.codes <= in_byte;
			item_s1.pred  <= pred_q;
			item_s1.shift <= shift_q;
		end
	end

	assign slot.valid = valid_q;
	assign slot.phase = phase_q;
	assign slot.item  = item_s1;

	a_phase_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_q && item_s1.emit)
		else $error("high-nibble phase without a sample byte in the slot");

endmodule

### design/vagdec_calc.sv
// Sample arithmetic: scaled code, two-tap prediction, history saturation and output rounding.
module vagdec_calc (
	input  vagdec_pkg::hist_t              newest,
	input  vagdec_pkg::hist_t              older,
	input  logic [vagdec_pkg::CODE_W-1:0]  code,
	input  logic [vagdec_pkg::PRED_W-1:0]  pred,
	input  logic [vagdec_pkg::SHIFT_W-1:0] shift,
	output vagdec_pkg::hist_t              q,
	output vagdec_pkg::sample_t            sample
);

	localparam int SUM_W = vagdec_pkg::HIST_W + vagdec_pkg::COEF_W + 1;
	localparam int QR_W  = SUM_W + 1;
	localparam int RND_W = vagdec_pkg::HIST_W + 1;
	localparam int QUO_W = RND_W - vagdec_pkg::FRAC_W;
	localparam logic signed [SUM_W-1:0] ROUND_S = SUM_W'(1) <<< (vagdec_pkg::FRAC_W - 1);
	localparam logic signed [RND_W-1:0] ROUND_R = RND_W'(1) <<< (vagdec_pkg::FRAC_W - 1);
	localparam logic signed [RND_W-1:0] TRUNC_FIX = RND_W'((1 << vagdec_pkg::FRAC_W) - 1);

	logic signed [vagdec_pkg::CODE_W-1:0] nib;
	logic signed [vagdec_pkg::BASE_W-1:0] scaled;
	logic signed [vagdec_pkg::BASE_W-1:0] base;
	logic signed [SUM_W-1:0]              prod_n;
	logic signed [SUM_W-1:0]              prod_o;
	logic signed [SUM_W-1:0]              acc;
	logic signed [SUM_W-1:0]              pred_v;
	logic signed [QR_W-1:0]               q_raw;
	logic                                 q_fits;
	logic signed [RND_W-1:0]              rnd;
	logic signed [RND_W-1:0]              adj;
	logic signed [QUO_W-1:0]              quo;
	logic                                 s_fits;

	assign nib    = signed'(code);
	assign scaled = {nib, {(vagdec_pkg::BASE_W - vagdec_pkg::CODE_W){1'b0}}};
	assign base   = scaled >>> shift;

	assign prod_n = SUM_W'(newest) * SUM_W'(vagdec_pkg::coef_newest(pred));
	assign prod_o = SUM_W'(older) * SUM_W'(vagdec_pkg::coef_older(pred));
	assign acc    = prod_n + prod_o + ROUND_S;
	assign pred_v = acc >>> vagdec_pkg::FRAC_W;

	assign q_raw  = QR_W'(pred_v) + (QR_W'(base) <<< vagdec_pkg::FRAC_W);
	// saturate: fits when all bits above the history sign bit match it
	assign q_fits = (q_raw[QR_W-1:vagdec_pkg::HIST_W-1] == '0) ||
	                (q_raw[QR_W-1:vagdec_pkg::HIST_W-1] == '1);

	always_comb begin
		if (q_fits)
			q = q_raw[vagdec_pkg::HIST_W-1:0];
		else if (q_raw[QR_W-1])
			q = {1'b1, {(vagdec_pkg::HIST_W-1){1'b0}}};
		else
			q = {1'b0, {(vagdec_pkg::HIST_W-1){1'b1}}};
	end

	// (q + 32) / 64 toward zero: bias negatives by 63 before the shift
	assign rnd = RND_W'(q) + ROUND_R;
	assign adj = rnd + (rnd[RND_W-1] ? TRUNC_FIX : '0);
	assign quo = adj[RND_W-1:vagdec_pkg::FRAC_W];
	assign s_fits = (quo[QUO_W-1:vagdec_pkg::SAMPLE_W-1] == '0) ||
	                (quo[QUO_W-1:vagdec_pkg::SAMPLE_W-1] == '1);

	always_comb begin
		if (s_fits)
			sample = quo[vagdec_pkg::SAMPLE_W-1:0];
		else if (quo[QUO_W-1])
			sample = {1'b1, {(vagdec_pkg::SAMPLE_W-1){1'b0}}};
		else
			sample = {1'b0, {(vagdec_pkg::SAMPLE_W-1){1'b1}}};
	end

endmodule

### design/vagdec_skid.sv
// Result register with a skid entry, so the upstream ready is a register.
module vagdec_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vagdec_pkg::sample_t in_sample,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output vagdec_pkg::sample_t out_sample,
	output logic                out_last
);

	logic                main_v_q;
	logic                skid_v_q;
	vagdec_pkg::sample_t main_sample_q;
	logic                main_last_q;
	vagdec_pkg::sample_t skid_sample_q;
	logic                skid_last_q;
	logic                fire;
	logic                drain;

	assign in_ready = !skid_v_q;
	assign fire     = in_valid && !skid_v_q;
	assign drain    = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (fire) begin
				if (main_v_q && !out_ready)
					skid_v_q <= 1'b1;
				else
					main_v_q <= 1'b1;
			end else if (drain) begin
				if (skid_v_q)
					skid_v_q <= 1'b0;
				else
					main_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !(main_v_q && !out_ready)) begin
			main_sample_q <= in_sample;
			main_last_q   <= in_last;
		end else if (fire) begin
			skid_sample_q <= in_sample;
			skid_last_q   <= in_last;
		end else if (drain && skid_v_q) begin
			main_sample_q <= skid_sample_q;
			main_last_q   <= skid_last_q;
		end
	end

	assign out_valid  = main_v_q;
	assign out_sample = main_sample_q;
	assign out_last   = main_last_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held while the result register is empty");

endmodule

### design/vag_adpcm_byte_decoder_unit.sv
// Top level of the VAG ADPCM byte decoder: framing, sample datapath, history and result buffer.
//
// Use:
//   Bytes of a VAG ADPCM stream enter on the s_ group, one byte a beat, in 16-byte
//   blocks: a header (predictor in the high nibble, shift in the low), a flags byte,
//   then fourteen sample bytes. s_tuser marks the first byte of a new stream, clears
//   the block position before that byte is taken and the history before it is decoded.
//   Every sample byte of a normal block leaves two beats on the m_ group: the
//   low-nibble sample with m_tlast low, then the high-nibble sample with m_tlast
//   high. Header and flags bytes, and all bytes of a block whose header is 0xC0,
//   give no beats.
// Sample flow:
//   Each byte is registered in the decode slot and its samples then in the result
//   register, low nibble first. The slot turns out one sample per cycle while the
//   result buffer has room, each depending on the one before it through the history
//   registers, so a sample byte holds it for a low-nibble step and then a high-nibble
//   step, while header, flags and fill bytes leave it without a sample.
// Reset and stall:
//   Reset empties the slot and the result buffer and zeroes history, position and
//   header state. When m_tready is low the result register and its skid entry hold
//   up to two samples; the slot then waits and s_tready drops until space frees.
module vag_adpcm_byte_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] stream_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast    // last_of_run: high-nibble sample of a byte
);

	vagdec_pkg::slot_t   slot;
	vagdec_pkg::hist_t   newest_q;
	vagdec_pkg::hist_t   older_q;
	vagdec_pkg::hist_t   newest_in;
	vagdec_pkg::hist_t   older_in;
	vagdec_pkg::hist_t   q;
	vagdec_pkg::sample_t sample;
	logic [vagdec_pkg::CODE_W-1:0] code;
	logic                skid_ready;
	logic                adv;
	logic                clr_now;

	// Decode slot: take bytes, track the block position and header.
	vagdec_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.adv      (adv),
		.slot     (slot)
	);

	// Advance the slot: sample steps need room in the result buffer, others go at once.
	assign adv     = slot.valid && (!slot.item.emit || skid_ready);
	// Stream start clears the history ahead of the first sample of its byte.
	assign clr_now = slot.item.clr && !slot.phase;
	assign newest_in = clr_now ? '0 : newest_q;
	assign older_in  = clr_now ? '0 : older_q;
	assign code      = slot.phase ? slot.item.codes[7:4] : slot.item.codes[3:0];

	vagdec_calc u_calc (
		.newest (newest_in),
		.older  (older_in),
		.code   (code),
		.pred   (slot.item.pred),
		.shift  (slot.item.shift),
		.q      (q),
		.sample (sample)
	);

	// History: shift in each decoded value; a stream start on a silent byte just clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			older_q  <= '0;
		end else if (adv && slot.item.emit) begin
			older_q  <= newest_in;
			newest_q <= q;
		end else if (adv && clr_now) begin
			older_q  <= '0;
			newest_q <= '0;
		end
	end

	vagdec_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (slot.valid && slot.item.emit),
		.in_ready   (skid_ready),
		.in_sample  (sample),
		.in_last    (slot.phase),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (m_tdata),
		.out_last   (m_tlast)
	);

	a_clear_on_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !slot.item.emit && clr_now |=> newest_q == '0 && older_q == '0)
		else $error("stream start on a silent byte left history set");

	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv && slot.item.emit |=> older_q == $past(newest_in) && newest_q == $past(q))
		else $error("history did not shift on a decoded sample");

	a_high_follows_low: assert property (@(posedge clk) disable iff (!arst_n)
		adv && slot.item.emit && !slot.phase |=> slot.valid && slot.phase)
		else $error("low-nibble step not followed by the high-nibble step");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the VAG ADPCM byte decoder: directed blocks, then random streams.
module tb_top;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES  = 570;

	typedef struct packed {
		vagdec_pkg::sample_t sample;
		logic                last;
	} pcm_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
	logic        s_tuser  = 1'b0; // [0] stream_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [15:0] sample
	logic        m_tlast;         // high-nibble sample of a byte

	// decoder state as the testbench sees it
	logic [vagdec_pkg::POS_W-1:0]   blk_pos   = vagdec_pkg::POS_HEADER;
	logic [vagdec_pkg::PRED_W-1:0]  blk_pred  = '0;
	logic [vagdec_pkg::SHIFT_W-1:0] blk_shift = '0;
	logic                           blk_fill  = 1'b0;
	longint                         hist_new  = 0;
	longint                         hist_old  = 0;

	pcm_beat_t pending_samples[$];
	pcm_beat_t beat_want;

	int feed_idle_pct   = 0;
	int sink_stall_pct  = 0;
	int cycle_count     = 0;
	int error_count     = 0;
	int bytes_sent      = 0;
	int samples_checked = 0;
	int fill_headers    = 0;
	int stream_starts   = 0;

	vag_adpcm_byte_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Weight of one history tap, in units of 1/64.
	function automatic longint tap_weight(input logic [vagdec_pkg::PRED_W-1:0] p,
	                                      input logic older);
		longint w;
		unique case (p)
			3'd1:    w = older ? 0   : 60;
			3'd2:    w = older ? -52 : 115;
			3'd3:    w = older ? -55 : 98;
			3'd4:    w = older ? -60 : 122;
			default: w = 0;
		endcase
		return w;
	endfunction

	// Decode one 4-bit code against the current block and advance the history.
	function automatic vagdec_pkg::sample_t decode_code(
		input logic [vagdec_pkg::CODE_W-1:0] code);
		longint nib, base, pred, q, s, hmax;
		nib  = code[vagdec_pkg::CODE_W-1] ? longint'(code) - 16 : longint'(code);
		base = (nib * 4096) >>> blk_shift;
		pred = (hist_new * tap_weight(blk_pred, 1'b0) +
		        hist_old * tap_weight(blk_pred, 1'b1) + 32) >>> vagdec_pkg::FRAC_W;
		q    = base * 64 + pred;
		hmax = (longint'(1) << (vagdec_pkg::HIST_W - 1)) - 1;
		if (q > hmax)
			q = hmax;
		else if (q < -hmax - 1)
			q = -hmax - 1;
		hist_old = hist_new;
		hist_new = q;
		s = (q + 32) / 64;
		if (s > 32767)
			s = 32767;
		else if (s < -32768)
			s = -32768;
		return vagdec_pkg::sample_t'(s);
	endfunction

	// Append one expected beat behind those already waiting.
	function automatic void queue_beat(input pcm_beat_t beat);
		pending_samples.insert(pending_samples.size(), beat);
	endfunction

	// Work out the samples that one accepted byte must give, oldest first.
	task automatic predict_byte_samples(input logic [7:0] b, input logic start);
		logic [vagdec_pkg::POS_W-1:0] here;
		pcm_beat_t                    lo_beat, hi_beat;
		if (start) begin
			blk_pos  = vagdec_pkg::POS_HEADER;
			hist_new = 0;
			hist_old = 0;
			stream_starts++;
		end
		here    = blk_pos;
		blk_pos = blk_pos + 1'b1;
		if (here == vagdec_pkg::POS_HEADER) begin
			blk_fill  = (b == vagdec_pkg::HEADER_FILL);
			blk_pred  = (b[7:4] > vagdec_pkg::PRED_MAX) ? '0 : b[6:4];
			blk_shift = b[3:0];
			if (blk_fill)
				fill_headers++;
		end else if (here >= vagdec_pkg::POS_FIRST_SAMPLE && !blk_fill) begin
			lo_beat.sample = decode_code(b[3:0]);
			lo_beat.last   = 1'b0;
			hi_beat.sample = decode_code(b[7:4]);
			hi_beat.last   = 1'b1;
			queue_beat(lo_beat);
			queue_beat(hi_beat);
		end
	endtask

	// Offer one byte, with random gaps first, and hold it until the beat is taken.
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < feed_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_byte_samples(b, start);
		bytes_sent++;
	endtask

	// Hold off the sender until every predicted sample has come out.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_header();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return vagdec_pkg::HEADER_FILL;
		else if (r < 22)
			return {4'($urandom_range(5, 15)), 4'($urandom_range(15))};
		return {4'($urandom_range(0, 4)), 4'($urandom_range(15))};
	endfunction

	// Mostly whole blocks of well-formed streams with random content; now and then a
	// ragged burst of raw bytes with stray stream starts to break the framing.
	task automatic random_streams(input int n);
		int         sent, k, blocks, junk;
		logic [7:0] b;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 12) begin
				junk = $urandom_range(1, 20);
				for (k = 0; k < junk && sent < n; k++) begin
					send_byte(8'($urandom), ($urandom_range(99) < 8));
					sent++;
				end
			end else begin
				blocks = $urandom_range(1, 6);
				for (k = 0; k < blocks * 16 && sent < n; k++) begin
					b = (k % 16 == 0) ? random_header() : 8'($urandom);
					send_byte(b, k == 0);
					sent++;
				end
			end
		end
	endtask

	// Predictors one to four, output clamping, extreme codes and a stream start
	// that cuts a block short.
	task automatic test_predictor_taps();
		send_byte(8'h1C, 1'b1);   // predictor one, shift twelve
		send_byte(8'hFF, 1'b0);   // flags byte: no samples
		send_byte(8'h77, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h4F, 1'b1);   // fresh stream mid-block
		send_byte(8'h00, 1'b0);
		send_byte(8'h99, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h3A, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h20, 1'b1);   // predictor two, no shift: drives into the clamp
		send_byte(8'h00, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h77, 1'b0);
		wait_all_results();
	endtask

	// Predictor above four falls back to no prediction.
	task automatic test_predictor_remap();
		send_byte(8'hF0, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h88, 1'b0);
		wait_all_results();
	endtask

	// Fill block: no samples; the stream start on its header clears the history.
	task automatic test_fill_block();
		send_byte(8'hC0, 1'b1);
		send_byte(8'h02, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h12, 1'b0);
		wait_all_results();
	endtask

	task automatic test_random_feed_idle();
		feed_idle_pct  = 20;
		sink_stall_pct = 82;
		random_streams(RANDOM_BYTES);
		wait_all_results();
	endtask

	task automatic test_random_sink_stall();
		feed_idle_pct  = 82;
		sink_stall_pct = 20;
		random_streams(RANDOM_BYTES);
		wait_all_results();
	endtask

	task automatic test_random_no_idle();
		feed_idle_pct  = 0;
		sink_stall_pct = 0;
		random_streams(RANDOM_BYTES);
		wait_all_results();
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Compare each sample beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample beat %0d last %0b",
				         $time, $signed(m_tdata), m_tlast);
				error_count++;
			end else begin
				beat_want = pending_samples.pop_front();
				samples_checked++;
				if (m_tdata !== beat_want.sample) begin
					$display("%0t: sample mismatch: expected %0d, got %0d",
					         $time, beat_want.sample, $signed(m_tdata));
					error_count++;
				end
				if (m_tlast !== beat_want.last) begin
					$display("%0t: tlast mismatch: expected %0b, got %0b",
					         $time, beat_want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d samples still expected",
			         $time, pending_samples.size());
			$display("** vag_adpcm_byte_decoder_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_predictor_taps();
		test_predictor_remap();
		test_fill_block();
		test_random_feed_idle();
		test_random_sink_stall();
		test_random_no_idle();

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d streams (%0d fill headers); checked %0d samples.",
		         bytes_sent, stream_starts, fill_headers, samples_checked);
		$display("Idling ran sender-light, receiver-light and free-running; %0d errors.",
		         error_count);
		if (error_count == 0)
			$display("** vag_adpcm_byte_decoder_unit: PASSED **");
		else
			$display("** vag_adpcm_byte_decoder_unit: FAILED **");
		$finish;
	end

endmodule
